FILE: rtl/core/obst_pkg.sv
// ----------------------------------------------------------------------------
// obst_pkg
// Shared types and constants for the occupancy bitmap segment tester.
// ----------------------------------------------------------------------------
`default_nettype none

package obst_pkg;

  localparam int DEF_GRID_ROWS     = 512;
  localparam int DEF_WORDS_PER_ROW = 8;
  localparam int COORD_W           = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ELEM  = 2'd1,
    ACT_WIRE  = 2'd2,
    ACT_TEST  = 2'd3
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture ordered endpoints and action
    logic clr_init;  // restart the clearing sweep
    logic clr_step;  // zero one word of both maps
    logic div;       // register lattice spans
    logic setup;     // load walk counters
    logic issue;     // read one map word
  } obst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic span_empty;
    logic walk_last;
    logic clr_last;
  } obst_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/obst_ctrl.sv
// ----------------------------------------------------------------------------
// obst_ctrl
// Sequencer: request accept, clearing sweep, span setup, word walk, result.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_ctrl
  import obst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_action,
  output logic            busy,
  output logic            out_valid,
  output obst_cmd_t       cmd,
  input  wire obst_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SETUP = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  logic    test_r, test_nxt;
  action_t act;

  assign act = action_t'(in_action);

  always_comb begin
    state_nxt = state_r;
    test_nxt  = test_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (act == ACT_CLEAR) begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLEAR;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
          end
          test_nxt = (act == ACT_TEST);
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.span_empty ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        if (stat.walk_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;  // maps are swept to zero after reset
      test_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      test_r  <= test_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE) && test_r;

endmodule

`default_nettype wire

FILE: rtl/core/obst_dp.sv
// ----------------------------------------------------------------------------
// obst_dp
// Datapath: endpoint ordering, lattice spans, word masks and the two maps.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_dp
  import obst_pkg::*;
#(
  parameter int GRID_ROWS     = DEF_GRID_ROWS,
  parameter int WORDS_PER_ROW = DEF_WORDS_PER_ROW
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         in_action,
  input  wire logic [COORD_W-1:0] in_x_first,
  input  wire logic [COORD_W-1:0] in_y_first,
  input  wire logic [COORD_W-1:0] in_x_last,
  input  wire logic [COORD_W-1:0] in_y_last,
  input  wire obst_cmd_t          cmd,
  output obst_stat_t              stat,
  output logic                    out_blocked
);

  localparam int DEPTH  = GRID_ROWS * WORDS_PER_ROW;
  localparam int AW     = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int WORD_W = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
  localparam int LAT_W  = 13;  // lattice index of a 16-bit coordinate

  localparam logic [AW-1:0]     ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(WORDS_PER_ROW - 1);
  localparam logic [LAT_W-1:0]  ROW_LAST  = LAT_W'(GRID_ROWS - 1);
  localparam logic [LAT_W-1:0]  ROW_CNT   = LAT_W'(GRID_ROWS);
  localparam logic [15:0]       RECIP10   = 16'hCCCD;  // 2^19 / 10, rounded up

  // floor(x / 10), exact for x below 81920
  function automatic logic [LAT_W-1:0] div10(input logic [16:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(RECIP10);
    return p[31:19];
  endfunction

  // bits of word w whose column lies below k
  function automatic logic [63:0] prefix_bits(input logic [LAT_W-1:0] k,
                                              input logic [6:0] w);
    logic [6:0] hi;
    hi = k[LAT_W-1:6];
    if (hi < w)      return '0;
    else if (hi > w) return '1;
    else             return (64'd1 << k[5:0]) - 64'd1;
  endfunction

  logic [63:0] hmap [DEPTH];
  logic [63:0] vmap [DEPTH];

  action_t            act_r;
  logic               flat_r;
  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [LAT_W-1:0]   cfirst_r, cend_r, rfirst_r, rlast_r;
  logic [ROW_W-1:0]   row_r, row_last_r;
  logic [WORD_W-1:0]  word_r;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               b_vld_r;
  logic [AW-1:0]      b_addr_r;
  logic [63:0]        b_mask_r;
  logic [63:0]        rd_h_r, rd_v_r;
  logic               hit_r, hit_nxt;

  logic               swap;
  logic [LAT_W-1:0]   rlast_clamp;
  logic [63:0]        mask;
  logic               mark_h, mark_v;
  logic               we_h, we_v;
  logic [AW-1:0]      wr_addr;
  logic [63:0]        wd_h, wd_v, probe;

  assign swap = (in_x_first > in_x_last) || (in_y_first > in_y_last);

  assign rlast_clamp = (rlast_r >= ROW_CNT) ? ROW_LAST : rlast_r;

  assign mask = prefix_bits(cfirst_r, 7'(word_r)) ^ prefix_bits(cend_r, 7'(word_r));

  assign stat.span_empty = (rfirst_r > rlast_clamp);
  assign stat.walk_last  = (row_r == row_last_r) && (word_r == WORD_LAST);
  assign stat.clr_last   = (addr_r == ADDR_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      flat_r <= (in_y_first == in_y_last);
      x0_r   <= swap ? in_x_last  : in_x_first;
      y0_r   <= swap ? in_y_last  : in_y_first;
      x1_r   <= swap ? in_x_first : in_x_last;
      y1_r   <= swap ? in_y_first : in_y_last;
    end
    if (cmd.div) begin
      cfirst_r <= div10(17'(x0_r) + 17'd9);
      cend_r   <= div10(17'(x1_r)) + LAT_W'(1);
      rfirst_r <= div10(17'(y0_r) + 17'd9);
      rlast_r  <= div10(17'(y1_r));
    end
    if (cmd.setup) begin
      row_r      <= rfirst_r[ROW_W-1:0];
      row_last_r <= rlast_clamp[ROW_W-1:0];
      word_r     <= '0;
    end else if (cmd.issue) begin
      if (word_r == WORD_LAST) begin
        word_r <= '0;
        row_r  <= row_r + ROW_W'(1);
      end else begin
        word_r <= word_r + WORD_W'(1);
      end
    end
    b_addr_r <= addr_r;
    b_mask_r <= mask;
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.clr_init)                  addr_nxt = '0;
    else if (cmd.setup)                addr_nxt = AW'(rfirst_r[ROW_W-1:0]) * AW'(WORDS_PER_ROW);
    else if (cmd.clr_step || cmd.issue) addr_nxt = addr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      b_vld_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      addr_r  <= addr_nxt;
      b_vld_r <= cmd.issue;
      hit_r   <= hit_nxt;
    end
  end

  // second walk stage: merge or probe the word read in the previous cycle
  assign mark_h = (act_r == ACT_ELEM) || ((act_r == ACT_WIRE) && !flat_r);
  assign mark_v = (act_r == ACT_ELEM) || ((act_r == ACT_WIRE) && flat_r);
  assign probe  = flat_r ? rd_h_r : rd_v_r;

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.setup) hit_nxt = 1'b0;
    else if (b_vld_r && (act_r == ACT_TEST) && ((probe & b_mask_r) != 64'd0))
      hit_nxt = 1'b1;
  end

  assign we_h    = cmd.clr_step || (b_vld_r && mark_h);
  assign we_v    = cmd.clr_step || (b_vld_r && mark_v);
  assign wr_addr = cmd.clr_step ? addr_r : b_addr_r;
  assign wd_h    = cmd.clr_step ? 64'd0 : (rd_h_r | b_mask_r);
  assign wd_v    = cmd.clr_step ? 64'd0 : (rd_v_r | b_mask_r);

  // walk addresses only increase, so a read never hits the word being written
  always_ff @(posedge clk) begin
    rd_h_r <= hmap[addr_r];
    rd_v_r <= vmap[addr_r];
    if (we_h) hmap[wr_addr] <= wd_h;
    if (we_v) vmap[wr_addr] <= wd_v;
  end

  assign out_blocked = hit_r;

endmodule

`default_nettype wire

FILE: rtl/core/occupancy_bitmap_segment_test.sv
// ----------------------------------------------------------------------------
// occupancy_bitmap_segment_test
// Two lattice occupancy bitmaps: clear, mark boxes and wires, test segments.
// ----------------------------------------------------------------------------
//  channel  ports                                      handshake
//  request  in_action, in_x_first .. in_y_last         start && !busy
//  result   out_blocked                                out_valid, one cycle
//
//  Mark/test: accept, span division, walk setup, a walk over every word of
//  the covered rows, a drain step, result. The walk moves one map word per
//  cycle through the map read/write port. An empty row span skips the walk.
//  Clear zeroes both maps; the same sweep runs after reset, with busy high.
//  The result strobe cannot be stalled; it comes only for test requests.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_bitmap_segment_test
  import obst_pkg::*;
#(
  parameter int GRID_ROWS     = DEF_GRID_ROWS,
  parameter int WORDS_PER_ROW = DEF_WORDS_PER_ROW
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [COORD_W-1:0] in_x_first,
  input  wire logic [COORD_W-1:0] in_y_first,
  input  wire logic [COORD_W-1:0] in_x_last,
  input  wire logic [COORD_W-1:0] in_y_last,
  output logic                    out_valid,
  output logic                    out_blocked
);

  obst_cmd_t  cmd;
  obst_stat_t stat;

  obst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  obst_dp #(
    .GRID_ROWS     (GRID_ROWS),
    .WORDS_PER_ROW (WORDS_PER_ROW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_action   (in_action),
    .in_x_first  (in_x_first),
    .in_y_first  (in_y_first),
    .in_x_last   (in_x_last),
    .in_y_last   (in_y_last),
    .cmd         (cmd),
    .stat        (stat),
    .out_blocked (out_blocked)
  );

endmodule

`default_nettype wire

FILE: rtl/core/obst_props.sv
// ----------------------------------------------------------------------------
// obst_props
// Port-level properties of the segment tester, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_props
  import obst_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_action,
  input wire logic       out_valid
);

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request was accepted");

  // the result comes while the request is still in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // one strobe per test, then the block is free again
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle or block stuck");

  // a non-test request never yields an immediate result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action != ACT_TEST)) |=> !out_valid)
    else $error("result strobe after a non-test request");

endmodule

bind occupancy_bitmap_segment_test obst_props u_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid)
);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the occupancy bitmap segment tester against a cycle-free model of
// its two lattice maps: directed corner cases, then mostly small boxes, wires
// and test segments near the origin with some full-range noise and clears.
// ----------------------------------------------------------------------------

module tb;
  import obst_pkg::*;

  localparam int ROWS         = DEF_GRID_ROWS;
  localparam int WPR          = DEF_WORDS_PER_ROW;
  localparam int PITCH        = 10;
  localparam int RANDOM_REQS  = 500;
  localparam int PHASE_LEN    = 50;
  localparam int DRAIN_CYCLES = ROWS * WPR + 64;

  typedef struct {
    action_t            action;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] x_last;
    logic [COORD_W-1:0] y_last;
  } seg_req_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic [1:0]         in_action  = '0;
  logic [COORD_W-1:0] in_x_first = '0;
  logic [COORD_W-1:0] in_y_first = '0;
  logic [COORD_W-1:0] in_x_last  = '0;
  logic [COORD_W-1:0] in_y_last  = '0;
  logic               busy;
  logic               out_valid;
  logic               out_blocked;

  occupancy_bitmap_segment_test DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_x_first (in_x_first),
    .in_y_first (in_y_first),
    .in_x_last  (in_x_last),
    .in_y_last  (in_y_last),
    .out_valid  (out_valid),
    .out_blocked(out_blocked)
  );

  always #4 clk = ~clk;

  // model copy of both maps
  bit [63:0] h_occ [ROWS*WPR];
  bit [63:0] v_occ [ROWS*WPR];

  seg_req_t pending_reqs[$];
  bit       expected_blocked[$];
  seg_req_t cur_req;
  logic     req_taken = 1'b0;

  int queued_total = 0;
  int issued       = 0;
  int accepted     = 0;
  int results_seen = 0;
  int hit_count    = 0;
  int mismatches   = 0;
  int act_count [4];

  // bits of word w whose column is below k
  function automatic bit [63:0] cols_below(int k, int w);
    int base;
    base = w * 64;
    if (k <= base) return '0;
    if (k >= base + 64) return '1;
    return (64'd1 << (k - base)) - 64'd1;
  endfunction

  task automatic apply_request(input seg_req_t r, output bit makes_result,
                               output bit blocked);
    int xa, ya, xb, yb, t;
    int cfirst, cend, rfirst, rlast, row, w, idx;
    bit flat, to_h, to_v, probe;
    bit [63:0] m;
    makes_result = 1'b0;
    blocked      = 1'b0;
    if (r.action == ACT_CLEAR) begin
      for (idx = 0; idx < ROWS * WPR; idx++) begin
        h_occ[idx] = '0;
        v_occ[idx] = '0;
      end
    end else begin
      xa = r.x_first;
      ya = r.y_first;
      xb = r.x_last;
      yb = r.y_last;
      if (xa > xb || ya > yb) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      flat  = (ya == yb);
      probe = (r.action == ACT_TEST);
      case (r.action)
        ACT_ELEM: begin
          to_h = 1'b1;
          to_v = 1'b1;
        end
        ACT_WIRE: begin
          to_h = !flat;
          to_v = flat;
        end
        default: begin
          // test reads the map named by its own orientation
          to_h = flat;
          to_v = !flat;
        end
      endcase
      cfirst = (xa + PITCH - 1) / PITCH;
      cend   = xb / PITCH + 1;
      rfirst = (ya + PITCH - 1) / PITCH;
      rlast  = yb / PITCH;
      if (rlast >= ROWS) rlast = ROWS - 1;
      for (row = rfirst; row <= rlast; row++) begin
        for (w = 0; w < WPR; w++) begin
          m   = cols_below(cfirst, w) ^ cols_below(cend, w);
          idx = row * WPR + w;
          if (probe) begin
            if (((to_h ? h_occ[idx] : v_occ[idx]) & m) != '0) blocked = 1'b1;
          end else begin
            if (to_h) h_occ[idx] |= m;
            if (to_v) v_occ[idx] |= m;
          end
        end
      end
      makes_result = probe;
    end
  endtask

  task automatic add_req(input action_t a, input int xf, input int yf,
                         input int xl, input int yl);
    seg_req_t r;
    r.action  = a;
    r.x_first = xf[COORD_W-1:0];
    r.y_first = yf[COORD_W-1:0];
    r.x_last  = xl[COORD_W-1:0];
    r.y_last  = yl[COORD_W-1:0];
    pending_reqs.push_back(r);
    queued_total++;
  endtask

  task automatic add_random_req();
    int pick, kind, x0, y0, x1, y1;
    action_t a;
    pick = $urandom_range(99);
    if (pick < 2) begin
      add_req(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 8) begin
      // full-range noise, mostly far off the grid or empty
      add_req(action_t'($urandom_range(3, 1)), $urandom, $urandom, $urandom, $urandom);
    end else begin
      x0 = $urandom_range(1500);
      y0 = $urandom_range(1500);
      if ($urandom_range(2) == 0) begin
        x0 = x0 / PITCH * PITCH;
        y0 = y0 / PITCH * PITCH;
      end
      kind = $urandom_range(2);
      case (kind)
        0: begin
          x1 = x0 + $urandom_range(300);
          y1 = y0;
        end
        1: begin
          x1 = x0;
          y1 = y0 + $urandom_range(80);
        end
        default: begin
          x1 = x0 + $urandom_range(200);
          y1 = y0 + $urandom_range(60);
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 20) a = ACT_ELEM;
      else if (pick < 50) a = ACT_WIRE;
      else a = ACT_TEST;
      if ($urandom_range(3) == 0) add_req(a, x1, y1, x0, y0);
      else add_req(a, x0, y0, x1, y1);
    end
  endtask

  function automatic int idle_pct_for(int n);
    case ((n / PHASE_LEN) % 4)
      1:       return 73;
      3:       return 13;
      default: return 0;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input bit want, input bit got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected blocked=%0b got %0b", $realtime, what, want, got);
  endtask

  // request accepted at this edge: predict its result
  always @(posedge clk) begin : accept_side
    bit makes, blk;
    req_taken <= start && !busy;
    if (rst_n && start && !busy) begin
      apply_request(cur_req, makes, blk);
      if (makes) expected_blocked.push_back(blk);
      act_count[cur_req.action]++;
      accepted++;
    end
  end

  always @(negedge clk) begin : request_driver
    seg_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // hold the request until it is taken
    end else if (pending_reqs.size() != 0 &&
                 $urandom_range(99) >= idle_pct_for(issued)) begin
      nxt = pending_reqs.pop_front();
      cur_req    <= nxt;
      start      <= 1'b1;
      in_action  <= nxt.action;
      in_x_first <= nxt.x_first;
      in_y_first <= nxt.y_first;
      in_x_last  <= nxt.x_last;
      in_y_last  <= nxt.y_last;
      issued++;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    bit want;
    if (rst_n && out_valid) begin
      if (expected_blocked.size() == 0) begin
        note_mismatch("unexpected result", 1'b0, out_blocked);
      end else begin
        want = expected_blocked.pop_front();
        results_seen++;
        if (out_blocked) hit_count++;
        if (out_blocked !== want) note_mismatch("blocked mismatch", want, out_blocked);
      end
    end
  end

  initial begin : stimulus
    int i;
    // empty maps, whole coordinate range
    add_req(ACT_TEST,  0, 0, 65535, 65535);
    // left edge at zero
    add_req(ACT_ELEM,  0, 0, 0, 0);
    add_req(ACT_TEST,  0, 0, 0, 0);
    // left edge on a word boundary (column 64)
    add_req(ACT_ELEM,  640, 100, 640, 100);
    add_req(ACT_TEST,  640, 100, 640, 100);
    add_req(ACT_TEST,  631, 100, 639, 100);
    // horizontal wire lands in the vertical map
    add_req(ACT_WIRE,  100, 200, 300, 200);
    add_req(ACT_TEST,  100, 200, 300, 200);
    add_req(ACT_TEST,  200, 150, 200, 250);
    // vertical wire, then crossing tests with reversed endpoints
    add_req(ACT_WIRE,  500, 300, 500, 400);
    add_req(ACT_TEST,  400, 350, 600, 350);
    add_req(ACT_TEST,  600, 350, 400, 350);
    // reversed column span after a y-driven swap
    add_req(ACT_WIRE,  450, 300, 450, 500);
    add_req(ACT_TEST,  400, 500, 600, 300);
    add_req(ACT_TEST,  203, 50, 205, 10);
    // empty row span
    add_req(ACT_TEST,  0, 11, 65535, 19);
    // outside the grid, then the last lattice point
    add_req(ACT_ELEM,  5120, 5120, 65535, 65535);
    add_req(ACT_TEST,  5110, 5110, 5110, 5110);
    add_req(ACT_ELEM,  5110, 5110, 65535, 65535);
    add_req(ACT_TEST,  5110, 5110, 5110, 5110);
    // diagonal wire marks its box in the horizontal map
    add_req(ACT_WIRE,  0, 0, 30, 30);
    add_req(ACT_TEST,  0, 10, 30, 20);
    add_req(ACT_CLEAR, 65535, 65535, 65535, 65535);
    add_req(ACT_TEST,  0, 0, 65535, 65535);
    for (i = 0; i < RANDOM_REQS; i++) add_random_req();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted < queued_total) @(posedge clk);
    while (expected_blocked.size() != 0) @(posedge clk);
    // a trailing clear or mark may still be running
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d clear, %0d box, %0d wire, %0d test",
             act_count[ACT_CLEAR], act_count[ACT_ELEM], act_count[ACT_WIRE],
             act_count[ACT_TEST]);
    $display("results checked: %0d (%0d blocked), mismatches: %0d",
             results_seen, hit_count, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("timeout: %0d of %0d requests taken, %0d results pending",
             accepted, queued_total, expected_blocked.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
